// ----- hdl/rgbhsv_pkg.sv -----
// Shared constants and types for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int SECTOR        = 60 * (2 ** HUE_FRAC_BITS);
  localparam int FULL_SCALE    = (2 ** CHANNEL_BITS) - 1;
  localparam int QUOT_BITS     = HUE_FRAC_BITS + 6;
  localparam int NUM_CELLS     = (QUOT_BITS > CHANNEL_BITS) ? QUOT_BITS : CHANNEL_BITS;
  localparam int DIV_BITS      = CHANNEL_BITS + NUM_CELLS;
  localparam int HUE_BITS      = HUE_FRAC_BITS + 9;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic                    grey;
    logic                    neg;
    sector_e                 sector;
    logic [CHANNEL_BITS-1:0] bright;
    logic [DIV_BITS-1:0]     hue_rem;
    logic [DIV_BITS-1:0]     hue_den;
    logic [NUM_CELLS-1:0]    hue_q;
    logic [DIV_BITS-1:0]     sat_rem;
    logic [DIV_BITS-1:0]     sat_den;
    logic [NUM_CELLS-1:0]    sat_q;
  } cell_t;

endpackage

// ----- hdl/rgbhsv_front.sv -----
// Front stages: max/min and sector pick, then delta and divider operands.
module rgbhsv_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  red_i,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  green_i,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  blue_i,
  output logic                                 valid_o,
  output rgbhsv_pkg::cell_t                    data_o
);

  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
  localparam int DW = rgbhsv_pkg::DIV_BITS;

  typedef struct packed {
    logic [CB-1:0]        hi;
    logic [CB-1:0]        lo;
    rgbhsv_pkg::sector_e  sector;
    logic signed [CB:0]   num;
  } front_t;

  front_t            a_d, a_q;
  logic              a_valid_q;
  rgbhsv_pkg::cell_t b_d, b_q;
  logic              b_valid_q;

  always_comb begin
    a_d.lo = red_i;
    if (green_i < a_d.lo) a_d.lo = green_i;
    if (blue_i < a_d.lo) a_d.lo = blue_i;
    if (red_i >= green_i && red_i >= blue_i) begin
      a_d.hi     = red_i;
      a_d.sector = rgbhsv_pkg::SEC_RED;
      a_d.num    = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      a_d.hi     = green_i;
      a_d.sector = rgbhsv_pkg::SEC_GREEN;
      a_d.num    = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      a_d.hi     = blue_i;
      a_d.sector = rgbhsv_pkg::SEC_BLUE;
      a_d.num    = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_comb begin
    logic [CB-1:0] delta;
    logic [CB:0]   abs_num;
    delta   = a_q.hi - a_q.lo;
    abs_num = a_q.num[CB] ? (~a_q.num + 1'b1) : a_q.num;
    b_d.grey    = (delta == '0);
    b_d.neg     = a_q.num[CB];
    b_d.sector  = a_q.sector;
    b_d.bright  = a_q.hi;
    b_d.hue_rem = DW'(abs_num[CB-1:0]) * DW'(rgbhsv_pkg::SECTOR);
    b_d.hue_den = DW'(delta) << (rgbhsv_pkg::NUM_CELLS - 1);
    b_d.hue_q   = '0;
    b_d.sat_rem = DW'(delta) * DW'(rgbhsv_pkg::FULL_SCALE);
    b_d.sat_den = DW'(a_q.hi) << (rgbhsv_pkg::NUM_CELLS - 1);
    b_d.sat_q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

// ----- hdl/rgbhsv_div_cell.sv -----
// Divider cell: one restoring step for hue and saturation quotients.
module rgbhsv_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rgbhsv_pkg::cell_t data_i,
  output logic              valid_o,
  output rgbhsv_pkg::cell_t data_o
);

  localparam int NC = rgbhsv_pkg::NUM_CELLS;

  rgbhsv_pkg::cell_t data_d, data_q;
  logic              valid_q;

  always_comb begin
    data_d = data_i;
    if (data_i.hue_rem >= data_i.hue_den) begin
      data_d.hue_rem = data_i.hue_rem - data_i.hue_den;
      data_d.hue_q   = {data_i.hue_q[NC-2:0], 1'b1};
    end else begin
      data_d.hue_q   = {data_i.hue_q[NC-2:0], 1'b0};
    end
    if (data_i.sat_rem >= data_i.sat_den) begin
      data_d.sat_rem = data_i.sat_rem - data_i.sat_den;
      data_d.sat_q   = {data_i.sat_q[NC-2:0], 1'b1};
    end else begin
      data_d.sat_q   = {data_i.sat_q[NC-2:0], 1'b0};
    end
    data_d.hue_den = data_i.hue_den >> 1;
    data_d.sat_den = data_i.sat_den >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hdl/rgbhsv_back.sv -----
// Back stage: floor correction, sector offset, wrap and output register.
module rgbhsv_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  rgbhsv_pkg::cell_t                    data_i,
  output logic                                 valid_o,
  output logic [rgbhsv_pkg::HUE_BITS-1:0]      hue_o,
  output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  saturation_o,
  output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  brightness_o
);

  localparam int HB = rgbhsv_pkg::HUE_BITS;
  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
  localparam int SW = HB + 2;

  logic          valid_q;
  logic [HB-1:0] hue_d, hue_q;
  logic [CB-1:0] sat_d, sat_q;
  logic [CB-1:0] bright_q;

  always_comb begin
    logic [HB-1:0]        mag;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] off;
    logic signed [SW-1:0] h;
    mag = HB'(data_i.hue_q);
    if (data_i.neg && data_i.hue_rem != '0) mag = mag + 1'b1;
    case (data_i.sector)
      rgbhsv_pkg::SEC_GREEN: base = SW'(2 * rgbhsv_pkg::SECTOR);
      rgbhsv_pkg::SEC_BLUE:  base = SW'(4 * rgbhsv_pkg::SECTOR);
      default:               base = '0;
    endcase
    off = $signed({2'b00, mag});
    h   = data_i.neg ? (base - off) : (base + off);
    if (h[SW-1]) h = h + SW'(6 * rgbhsv_pkg::SECTOR);
    hue_d = data_i.grey ? '0 : h[HB-1:0];
    sat_d = data_i.grey ? '0 : data_i.sat_q[CB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= data_i.bright;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

// ----- hdl/rgb_to_hsv_converter.sv -----
// RGB to HSV converter top level: input skid word, front stages, cell chain, back stage.
// From acceptance, a word passes the front registers, the divider cells and the output register.
// Throughput: one word per cycle unless out_stall_i holds a result; NUM_CELLS divider cells set the depth.
// Every stage advances unless a result waits and out_stall_i is high; one input word is
// then held in a skid register and in_stall_o rises until it moves on.
// Reset clears all valid flags and the skid flag; data registers are not reset.
module rgb_to_hsv_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  red_i,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  green_i,
  input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rgbhsv_pkg::HUE_BITS-1:0]      hue_o,
  output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  saturation_o,
  output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  brightness_o
);

  localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
  localparam int NC = rgbhsv_pkg::NUM_CELLS;

  logic          advance;
  logic          in_accept;
  logic          skid_valid_q;
  logic [CB-1:0] skid_red_q, skid_green_q, skid_blue_q;
  logic          f_valid;
  logic [CB-1:0] f_red, f_green, f_blue;

  rgbhsv_pkg::cell_t chain_data  [NC+1];
  logic              chain_valid [NC+1];

  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!advance && in_accept) begin
      skid_red_q   <= red_i;
      skid_green_q <= green_i;
      skid_blue_q  <= blue_i;
    end
  end

  assign f_valid = skid_valid_q || in_accept;
  assign f_red   = skid_valid_q ? skid_red_q   : red_i;
  assign f_green = skid_valid_q ? skid_green_q : green_i;
  assign f_blue  = skid_valid_q ? skid_blue_q  : blue_i;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (f_valid),
    .red_i   (f_red),
    .green_i (f_green),
    .blue_i  (f_blue),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    rgbhsv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (chain_valid[NC]),
    .data_i       (chain_data[NC]),
    .valid_o      (out_valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

  a_skid_only_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(!advance))
    else $error("skid loaded while pipeline advanced");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && advance) |=> !skid_valid_q)
    else $error("skid word not drained on advance");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < rgbhsv_pkg::HUE_BITS'(6 * rgbhsv_pkg::SECTOR)))
    else $error("hue out of range");

  a_sat_needs_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturation_o != '0) |-> (brightness_o != '0))
    else $error("nonzero saturation with zero value");

endmodule
